// ===== rtl/core/dacc_pkg.sv =====
// Shared types, constants and helpers for the decimal amount compression codec.
// No dependencies; every other file in rtl/core imports this package.
package dacc_pkg;

    localparam int VALUE_W    = 64;
    localparam int REM_W      = 4;
    localparam int CHUNK_W    = 8;
    localparam int CELL_COUNT = VALUE_W / CHUNK_W;

    localparam logic OP_COMPRESS   = 1'b0;
    localparam logic OP_DECOMPRESS = 1'b1;

    localparam logic [REM_W-1:0] E_STRIP_MAX = 4'd9;
    localparam logic [REM_W:0]   DIV_TEN     = 5'd10;
    localparam logic [REM_W:0]   DIV_NINE    = 5'd9;

    // Largest value that can still be multiplied by ten without leaving 64 bits.
    localparam logic [VALUE_W-1:0] MAX_DIV10 = 64'd1844674407370955161;

    // One beat travelling down the divider chain.
    typedef struct packed {
        logic               vld;
        logic               div9;
        logic [VALUE_W-1:0] num;
        logic [VALUE_W-1:0] quo;
        logic [REM_W-1:0]   rem;
    } div_beat_t;

    // Multiply by ten with shifts and one add, wrapping modulo 2^64.
    function automatic logic [VALUE_W-1:0] times10(input logic [VALUE_W-1:0] x);
        times10 = (x << 3) + (x << 1);
    endfunction

endpackage

// ===== rtl/core/dacc_div_cell.sv =====
// One cell of the constant divider chain: long division of one dividend chunk.
// Depends on dacc_pkg for the beat type and the chunk width.
module dacc_div_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  dacc_pkg::div_beat_t cell_in,
    output dacc_pkg::div_beat_t cell_out
);
    import dacc_pkg::*;

    logic        vld_reg;
    div_beat_t   payload_reg;
    div_beat_t   payload_next;
    logic [CHUNK_W-1:0] qbits;

    // Restoring division by nine or ten over the top chunk of the dividend.
    always_comb begin
        logic [REM_W:0]   t;
        logic [REM_W-1:0] r;
        logic [REM_W:0]   dv;
        r     = cell_in.rem;
        dv    = cell_in.div9 ? DIV_NINE : DIV_TEN;
        qbits = '0;
        t     = '0;
        for (int i = 0; i < CHUNK_W; i++) begin
            t = {r, cell_in.num[VALUE_W-1-i]};
            if (t >= dv) begin
                t = t - dv;
                qbits[CHUNK_W-1-i] = 1'b1;
            end
            r = t[REM_W-1:0];
        end
        payload_next      = cell_in;
        payload_next.num  = cell_in.num << CHUNK_W;
        payload_next.quo  = {cell_in.quo[VALUE_W-CHUNK_W-1:0], qbits};
        payload_next.rem  = r;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= cell_in.vld;
        end
        payload_reg <= payload_next;
    end

    always_comb begin
        cell_out     = payload_reg;
        cell_out.vld = vld_reg;
    end

endmodule

// ===== rtl/core/decimal_amount_compression_codec.sv =====
// Top level of the decimal amount compression codec: control sequencer and divider chain.
// Depends on dacc_pkg and dacc_div_cell.
//
// The codec takes one beat holding an opcode (s_tuser) and a 64-bit value (s_tdata) and
// returns one beat holding a 64-bit result (m_tdata) and an overflow flag (m_tuser).
// Compression strips up to nine trailing decimal zeros and, unless it stripped nine, folds
// the last remaining digit into the code; decompression undoes it, raising overflow when a
// rescale by ten runs past 64 bits (the result then holds the wrapped low bits). Every
// division by ten or nine runs through a chain of eight identical cells, each doing long
// division on one byte of the dividend and passing the partial quotient and remainder to
// its neighbor. The block works on one item at a time: a zero value skips the divider,
// a compression runs at most nine divisions by ten, and a decompression runs one division
// by ten and, unless the exponent is nine, one by nine, then one rescale by ten per
// decimal exponent step (up to nine). A finished result sits in the output register, and
// the next input beat is accepted while it waits to be taken.
module decimal_amount_compression_codec (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [dacc_pkg::VALUE_W-1:0]  s_tdata,   // [63:0] value
    input  logic [0:0]                    s_tuser,   // [0] opcode
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [dacc_pkg::VALUE_W-1:0]  m_tdata,   // [63:0] result
    output logic [0:0]                    m_tuser    // [0] overflow
);
    import dacc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_C_WAIT,
        S_C_MUL9,
        S_C_FIN,
        S_D_WAIT10,
        S_D_WAIT9,
        S_D_SCALE,
        S_OUT
    } state_t;

    state_t             state_reg, state_next;
    logic [VALUE_W-1:0] n_reg, n_next;
    logic [REM_W-1:0]   e_reg, e_next;
    logic [REM_W-1:0]   d_reg, d_next;
    logic               ovf_reg, ovf_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [VALUE_W-1:0] m_tdata_reg, m_tdata_next;
    logic               m_tuser_reg, m_tuser_next;

    div_beat_t          chain [CELL_COUNT+1];
    logic [CELL_COUNT-1:0] cell_vld;
    div_beat_t          div_in;
    div_beat_t          div_out;

    // The divider chain: beats enter at chain[0] and leave at chain[CELL_COUNT].
    for (genvar g = 0; g < CELL_COUNT; g++) begin : g_cell
        dacc_div_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .cell_in  (chain[g]),
            .cell_out (chain[g+1])
        );
        assign cell_vld[g] = chain[g+1].vld;
    end

    assign chain[0] = div_in;
    assign div_out  = chain[CELL_COUNT];
    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        state_next    = state_reg;
        n_next        = n_reg;
        e_next        = e_reg;
        d_next        = d_reg;
        ovf_next      = ovf_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        div_in        = '0;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    ovf_next = 1'b0;
                    e_next   = '0;
                    if (s_tdata == '0) begin
                        n_next     = '0;
                        state_next = S_OUT;
                    end else if (s_tuser[0] == OP_DECOMPRESS) begin
                        // The code is offset by one; divide (code - 1) by ten first.
                        div_in.vld = 1'b1;
                        div_in.num = s_tdata - 64'd1;
                        state_next = S_D_WAIT10;
                    end else begin
                        div_in.vld = 1'b1;
                        div_in.num = s_tdata;
                        state_next = S_C_WAIT;
                    end
                end
            end
            S_C_WAIT: begin
                if (div_out.vld) begin
                    if (div_out.rem == '0) begin
                        if (e_reg == E_STRIP_MAX - 4'd1) begin
                            // Ninth zero stripped: the code reduces to ten times the rest.
                            e_next     = E_STRIP_MAX;
                            n_next     = times10(div_out.quo);
                            state_next = S_OUT;
                        end else begin
                            e_next     = e_reg + 4'd1;
                            div_in.vld = 1'b1;
                            div_in.num = div_out.quo;
                        end
                    end else begin
                        n_next     = div_out.quo;
                        d_next     = div_out.rem;
                        state_next = S_C_MUL9;
                    end
                end
            end
            S_C_MUL9: begin
                n_next     = (n_reg << 3) + n_reg + VALUE_W'(d_reg - 4'd1);
                state_next = S_C_FIN;
            end
            S_C_FIN: begin
                n_next     = times10(n_reg) + VALUE_W'(e_reg) + 64'd1;
                state_next = S_OUT;
            end
            S_D_WAIT10: begin
                if (div_out.vld) begin
                    e_next = div_out.rem;
                    if (div_out.rem < E_STRIP_MAX) begin
                        div_in.vld  = 1'b1;
                        div_in.div9 = 1'b1;
                        div_in.num  = div_out.quo;
                        state_next  = S_D_WAIT9;
                    end else begin
                        n_next     = div_out.quo + 64'd1;
                        state_next = S_D_SCALE;
                    end
                end
            end
            S_D_WAIT9: begin
                if (div_out.vld) begin
                    n_next     = times10(div_out.quo) + VALUE_W'(div_out.rem) + 64'd1;
                    state_next = S_D_SCALE;
                end
            end
            S_D_SCALE: begin
                if (e_reg == '0) begin
                    state_next = S_OUT;
                end else begin
                    if (n_reg > MAX_DIV10) begin
                        ovf_next = 1'b1;
                    end
                    n_next = times10(n_reg);
                    e_next = e_reg - 4'd1;
                end
            end
            S_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = n_reg;
                    m_tuser_next  = ovf_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        n_reg       <= n_next;
        e_reg       <= e_next;
        d_reg       <= d_next;
        ovf_reg     <= ovf_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

    // At most one division is ever in flight in the chain.
    a_one_division: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(cell_vld) <= 1)
        else $error("more than one division in the divider chain");

    // A quotient only leaves the chain while the sequencer is waiting for one.
    a_out_expected: assert property (@(posedge aclk) disable iff (!aresetn)
        div_out.vld |-> (state_reg == S_C_WAIT || state_reg == S_D_WAIT10 ||
                         state_reg == S_D_WAIT9))
        else $error("divider result arrived in a state that does not wait for it");

    // The chain is empty whenever a new beat may be accepted.
    a_idle_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_IDLE |-> cell_vld == '0)
        else $error("division in flight while idle");

    // Compression never strips more than nine zeros.
    a_strip_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_C_WAIT |-> e_reg < E_STRIP_MAX)
        else $error("zero strip count out of range");

endmodule
